// ===== src/esc_pkg.sv =====
// ---------------------------------------------------------------------------
// esc_pkg: shared types and constants of the sensor compensation unit
// Item structs, sequencer step codes, register indexes and status codes.
// ---------------------------------------------------------------------------
package esc_pkg;

	typedef struct packed {
		logic [23:0] raw_temp;
		logic [23:0] raw_press;
		logic [15:0] raw_hum;
	} in_item_t;

	typedef struct packed {
		logic signed [23:0] temp_centi;
		logic               temp_ok;
		logic [31:0]        press_q24_8;
		logic [1:0]         press_status;
		logic [16:0]        hum_q22_10;
		logic               hum_ok;
	} out_item_t;

	// configuration register indexes
	localparam logic [2:0] CFG_TEMP    = 3'd0;
	localparam logic [2:0] CFG_PRESS_A = 3'd1;
	localparam logic [2:0] CFG_PRESS_B = 3'd2;
	localparam logic [2:0] CFG_PRESS_C = 3'd3;
	localparam logic [2:0] CFG_HUM     = 3'd4;

	// pressure status codes
	localparam logic [1:0] PST_OK   = 2'd0;
	localparam logic [1:0] PST_OFF  = 2'd1;
	localparam logic [1:0] PST_DIVZ = 2'd2;

	// disabled markers
	localparam logic [23:0] RAW_OFF24 = 24'h800000;
	localparam logic [15:0] RAW_OFF16 = 16'h8000;

	// step kinds
	localparam logic [1:0] KIND_ALU = 2'd0;
	localparam logic [1:0] KIND_MUL = 2'd1;
	localparam logic [1:0] KIND_DIV = 2'd2;

	// sequencer steps
	localparam logic [5:0] S_IDLE  = 6'd0;
	localparam logic [5:0] S_START = 6'd1;
	localparam logic [5:0] S_T0  = 6'd2;
	localparam logic [5:0] S_T1  = 6'd3;
	localparam logic [5:0] S_T2  = 6'd4;
	localparam logic [5:0] S_T3  = 6'd5;
	localparam logic [5:0] S_T4  = 6'd6;
	localparam logic [5:0] S_T5  = 6'd7;
	localparam logic [5:0] S_T6  = 6'd8;
	localparam logic [5:0] S_P0  = 6'd9;
	localparam logic [5:0] S_P1  = 6'd10;
	localparam logic [5:0] S_P2  = 6'd11;
	localparam logic [5:0] S_P3  = 6'd12;
	localparam logic [5:0] S_P4  = 6'd13;
	localparam logic [5:0] S_P5  = 6'd14;
	localparam logic [5:0] S_P6  = 6'd15;
	localparam logic [5:0] S_P7  = 6'd16;
	localparam logic [5:0] S_P8  = 6'd17;
	localparam logic [5:0] S_P9  = 6'd18;
	localparam logic [5:0] S_P10 = 6'd19;
	localparam logic [5:0] S_P11 = 6'd20;
	localparam logic [5:0] S_P12 = 6'd21;
	localparam logic [5:0] S_P13 = 6'd22;
	localparam logic [5:0] S_P14 = 6'd23;
	localparam logic [5:0] S_P15 = 6'd24;
	localparam logic [5:0] S_P16 = 6'd25;
	localparam logic [5:0] S_P17 = 6'd26;
	localparam logic [5:0] S_P18 = 6'd27;
	localparam logic [5:0] S_P19 = 6'd28;
	localparam logic [5:0] S_P20 = 6'd29;
	localparam logic [5:0] S_P21 = 6'd30;
	localparam logic [5:0] S_P22 = 6'd31;
	localparam logic [5:0] S_P23 = 6'd32;
	localparam logic [5:0] S_P24 = 6'd33;
	localparam logic [5:0] S_H0  = 6'd34;
	localparam logic [5:0] S_H1  = 6'd35;
	localparam logic [5:0] S_H2  = 6'd36;
	localparam logic [5:0] S_H3  = 6'd37;
	localparam logic [5:0] S_H4  = 6'd38;
	localparam logic [5:0] S_H5  = 6'd39;
	localparam logic [5:0] S_H6  = 6'd40;
	localparam logic [5:0] S_H7  = 6'd41;
	localparam logic [5:0] S_H8  = 6'd42;
	localparam logic [5:0] S_H9  = 6'd43;
	localparam logic [5:0] S_H10 = 6'd44;
	localparam logic [5:0] S_H11 = 6'd45;
	localparam logic [5:0] S_H12 = 6'd46;
	localparam logic [5:0] S_H13 = 6'd47;
	localparam logic [5:0] S_H14 = 6'd48;
	localparam logic [5:0] S_H15 = 6'd49;
	localparam logic [5:0] S_H16 = 6'd50;
	localparam logic [5:0] S_H17 = 6'd51;
	localparam logic [5:0] S_H18 = 6'd52;
	localparam logic [5:0] S_FIN = 6'd53;

	typedef struct packed {
		logic [5:0] step;
		logic       go;
		logic       load_in;
		logic       load_out;
	} esc_cmd_t;

	typedef struct packed {
		logic mul_done;
		logic div_done;
		logic mul_busy;
		logic div_busy;
		logic t_en;
		logic p_en;
		logic h_en;
		logic a_zero;
		logic out_free;
	} esc_stat_t;

	// which unit a step uses
	function automatic logic [1:0] step_kind(input logic [5:0] step);
		logic [1:0] k;
		case (step)
			S_T1, S_T2, S_T4, S_P1, S_P2, S_P3, S_P6, S_P7, S_P10, S_P14,
			S_P17, S_P18, S_P20, S_H1, S_H4, S_H6, S_H8, S_H10, S_H12,
			S_H14, S_H16: k = KIND_MUL;
			S_P15:        k = KIND_DIV;
			default:      k = KIND_ALU;
		endcase
		return k;
	endfunction

	// wrap to 32 bits and sign extend
	function automatic logic signed [63:0] w32(input logic signed [63:0] x);
		return $signed({{32{x[31]}}, x[31:0]});
	endfunction

endpackage

// ===== src/esc_mul.sv =====
// ---------------------------------------------------------------------------
// esc_mul: shared wrapping multiplier
// 64 x 64 product modulo 2^64, one 16-bit digit of b per cycle.
// ---------------------------------------------------------------------------
module esc_mul (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic        busy,
	output logic        done,
	output logic [63:0] p
);

	logic [63:0] a_q;
	logic [63:0] b_q;
	logic [63:0] acc_q;
	logic [1:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [79:0] part;

	assign part = a_q * b_q[15:0];

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 2'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd3) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// accumulate one digit a cycle
	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= 64'd0;
		end else if (busy_q) begin
			acc_q <= acc_q + part[63:0];
			a_q   <= {a_q[47:0], 16'd0};
			b_q   <= {16'd0, b_q[63:16]};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign p    = acc_q;

endmodule

// ===== src/esc_div.sv =====
// ---------------------------------------------------------------------------
// esc_div: serial signed divider
// 64-bit quotient truncated toward zero, restoring, one bit per cycle.
// ---------------------------------------------------------------------------
module esc_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] num,
	input  logic [63:0] den,
	output logic        busy,
	output logic        done,
	output logic [63:0] quo
);

	logic [63:0] n_q;
	logic [63:0] d_q;
	logic [63:0] r_q;
	logic        neg_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [64:0] r_sh;
	logic [65:0] diff;

	assign r_sh = {r_q, n_q[63]};
	assign diff = {1'b0, r_sh} - {2'b00, d_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 6'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// shift in one quotient bit a cycle
	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= num[63] ? (64'd0 - num) : num;
			d_q   <= den[63] ? (64'd0 - den) : den;
			r_q   <= 64'd0;
			neg_q <= num[63] ^ den[63];
		end else if (busy_q) begin
			if (!diff[65]) begin
				r_q <= diff[63:0];
				n_q <= {n_q[62:0], 1'b1};
			end else begin
				r_q <= r_sh[63:0];
				n_q <= {n_q[62:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo  = neg_q ? (64'd0 - n_q) : n_q;

endmodule

// ===== src/esc_datapath.sv =====
// ---------------------------------------------------------------------------
// esc_datapath: working registers, trims and result register
// Executes one sequencer step per command on four 64-bit registers.
// ---------------------------------------------------------------------------
module esc_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  esc_pkg::esc_cmd_t   cmd,
	output esc_pkg::esc_stat_t  st,
	input  esc_pkg::in_item_t   sample,
	input  logic                cfg_valid,
	input  logic [2:0]          cfg_index,
	input  logic [63:0]         cfg_data,
	output logic                result_valid,
	input  logic                result_stall,
	output esc_pkg::out_item_t  result
);

	logic [47:0] cal_temp_q;
	logic [63:0] cal_press_a_q;
	logic [63:0] cal_press_b_q;
	logic [15:0] cal_press_c_q;
	logic [63:0] cal_hum_q;
	logic [31:0] fine_q;

	esc_pkg::in_item_t  in_q;
	esc_pkg::out_item_t res_q;
	esc_pkg::out_item_t out_q;
	logic               out_valid_q;

	logic signed [63:0] ra_q, rb_q, rc_q, rd_q;
	logic signed [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
	logic signed [63:0] h1, h2, h3, h4, h5, h6;
	logic signed [63:0] fine_s, f5, tc, ps, hv;

	logic [63:0] mul_a, mul_b, mul_p, div_q;
	logic        mul_start, div_start, mul_done, div_done, mul_busy, div_busy;
	logic        go_alu;

	// trim fields
	assign t1 = $signed({48'd0, cal_temp_q[15:0]});
	assign t2 = $signed({{48{cal_temp_q[31]}}, cal_temp_q[31:16]});
	assign t3 = $signed({{48{cal_temp_q[47]}}, cal_temp_q[47:32]});
	assign p1 = $signed({48'd0, cal_press_a_q[15:0]});
	assign p2 = $signed({{48{cal_press_a_q[31]}}, cal_press_a_q[31:16]});
	assign p3 = $signed({{48{cal_press_a_q[47]}}, cal_press_a_q[47:32]});
	assign p4 = $signed({{48{cal_press_a_q[63]}}, cal_press_a_q[63:48]});
	assign p5 = $signed({{48{cal_press_b_q[15]}}, cal_press_b_q[15:0]});
	assign p6 = $signed({{48{cal_press_b_q[31]}}, cal_press_b_q[31:16]});
	assign p7 = $signed({{48{cal_press_b_q[47]}}, cal_press_b_q[47:32]});
	assign p8 = $signed({{48{cal_press_b_q[63]}}, cal_press_b_q[63:48]});
	assign p9 = $signed({{48{cal_press_c_q[15]}}, cal_press_c_q});
	assign h1 = $signed({56'd0, cal_hum_q[7:0]});
	assign h2 = $signed({{48{cal_hum_q[23]}}, cal_hum_q[23:8]});
	assign h3 = $signed({56'd0, cal_hum_q[31:24]});
	assign h4 = $signed({{52{cal_hum_q[43]}}, cal_hum_q[43:32]});
	assign h5 = $signed({{52{cal_hum_q[55]}}, cal_hum_q[55:44]});
	assign h6 = $signed({{56{cal_hum_q[63]}}, cal_hum_q[63:56]});

	assign fine_s = $signed({{32{fine_q[31]}}, fine_q});
	assign f5     = (fine_s <<< 2) + fine_s;
	assign tc     = (f5 + 64'sd128) >>> 8;
	assign ps     = (rb_q >>> 8) + (p7 <<< 4);
	assign hv     = esc_pkg::w32(ra_q - rc_q);

	assign go_alu = cmd.go && (esc_pkg::step_kind(cmd.step) == esc_pkg::KIND_ALU);

	// operand select for the shared multiplier
	always_comb begin
		mul_a = ra_q;
		mul_b = rb_q;
		unique case (cmd.step)
			esc_pkg::S_T1:  begin mul_a = ra_q; mul_b = t2;   end
			esc_pkg::S_T2:  begin mul_a = rb_q; mul_b = rb_q; end
			esc_pkg::S_T4:  begin mul_a = rb_q; mul_b = t3;   end
			esc_pkg::S_P1:  begin mul_a = ra_q; mul_b = ra_q; end
			esc_pkg::S_P2:  begin mul_a = rb_q; mul_b = p6;   end
			esc_pkg::S_P3:  begin mul_a = ra_q; mul_b = p5;   end
			esc_pkg::S_P6:  begin mul_a = rb_q; mul_b = p3;   end
			esc_pkg::S_P7:  begin mul_a = ra_q; mul_b = p2;   end
			esc_pkg::S_P10: begin mul_a = ra_q; mul_b = p1;   end
			esc_pkg::S_P14: begin mul_a = rb_q; mul_b = 64'd3125; end
			esc_pkg::S_P17: begin mul_a = rc_q; mul_b = p9;   end
			esc_pkg::S_P18: begin mul_a = rd_q; mul_b = rc_q; end
			esc_pkg::S_P20: begin mul_a = rb_q; mul_b = p8;   end
			esc_pkg::S_H1:  begin mul_a = ra_q; mul_b = h5;   end
			esc_pkg::S_H4:  begin mul_a = ra_q; mul_b = h3;   end
			esc_pkg::S_H6:  begin mul_a = ra_q; mul_b = h6;   end
			esc_pkg::S_H8:  begin mul_a = rd_q; mul_b = rc_q; end
			esc_pkg::S_H10: begin mul_a = rd_q; mul_b = h2;   end
			esc_pkg::S_H12: begin mul_a = rb_q; mul_b = rd_q; end
			esc_pkg::S_H14: begin mul_a = rc_q; mul_b = rc_q; end
			esc_pkg::S_H16: begin mul_a = rc_q; mul_b = h1;   end
			default: ;
		endcase
	end

	assign mul_start = cmd.go && (esc_pkg::step_kind(cmd.step) == esc_pkg::KIND_MUL);
	assign div_start = cmd.go && (esc_pkg::step_kind(cmd.step) == esc_pkg::KIND_DIV);

	esc_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.busy   (mul_busy),
		.done   (mul_done),
		.p      (mul_p)
	);

	esc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (rb_q),
		.den    (ra_q),
		.busy   (div_busy),
		.done   (div_done),
		.quo    (div_q)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_temp_q    <= '0;
			cal_press_a_q <= '0;
			cal_press_b_q <= '0;
			cal_press_c_q <= '0;
			cal_hum_q     <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				esc_pkg::CFG_TEMP:    cal_temp_q    <= cfg_data[47:0];
				esc_pkg::CFG_PRESS_A: cal_press_a_q <= cfg_data;
				esc_pkg::CFG_PRESS_B: cal_press_b_q <= cfg_data;
				esc_pkg::CFG_PRESS_C: cal_press_c_q <= cfg_data[15:0];
				esc_pkg::CFG_HUM:     cal_hum_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// fine temperature state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fine_q <= 32'd0;
		end else if (go_alu && cmd.step == esc_pkg::S_T5) begin
			fine_q <= 32'(ra_q + (rb_q >>> 14));
		end
	end

	// working registers and result fields
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			in_q <= sample;
		end
		if (mul_done) begin
			unique case (cmd.step)
				esc_pkg::S_T1, esc_pkg::S_P10, esc_pkg::S_P20, esc_pkg::S_H12:
					ra_q <= $signed(mul_p);
				esc_pkg::S_T2, esc_pkg::S_T4, esc_pkg::S_P1, esc_pkg::S_P6,
				esc_pkg::S_P14:
					rb_q <= $signed(mul_p);
				esc_pkg::S_P2, esc_pkg::S_H1, esc_pkg::S_H4, esc_pkg::S_H14,
				esc_pkg::S_H16:
					rc_q <= $signed(mul_p);
				default:
					rd_q <= $signed(mul_p);
			endcase
		end
		if (div_done) begin
			rb_q <= $signed(div_q);
		end
		if (go_alu) begin
			unique case (cmd.step)
				esc_pkg::S_START: begin
					res_q.temp_centi   <= '0;
					res_q.temp_ok      <= 1'b0;
					res_q.press_q24_8  <= '0;
					res_q.press_status <= esc_pkg::PST_OFF;
					res_q.hum_q22_10   <= '0;
					res_q.hum_ok       <= 1'b0;
				end
				esc_pkg::S_T0: begin
					ra_q <= $signed({47'd0, in_q.raw_temp[23:7]}) - (t1 <<< 1);
					rb_q <= $signed({48'd0, in_q.raw_temp[23:8]}) - t1;
				end
				esc_pkg::S_T3: begin
					ra_q <= ra_q >>> 11;
					rb_q <= rb_q >>> 12;
				end
				esc_pkg::S_T6: begin
					if (tc > 64'sd8388607)
						res_q.temp_centi <= 24'sd8388607;
					else if (tc < -64'sd8388608)
						res_q.temp_centi <= -24'sd8388608;
					else
						res_q.temp_centi <= $signed(tc[23:0]);
					res_q.temp_ok <= 1'b1;
				end
				esc_pkg::S_P0:  ra_q <= fine_s - 64'sd128000;
				esc_pkg::S_P4:  rc_q <= rc_q + (rd_q <<< 17);
				esc_pkg::S_P5:  rc_q <= rc_q + (p4 <<< 35);
				esc_pkg::S_P8:  ra_q <= (rb_q >>> 8) + (rd_q <<< 12);
				esc_pkg::S_P9:  ra_q <= ra_q + (64'sd1 <<< 47);
				esc_pkg::S_P11: ra_q <= ra_q >>> 33;
				esc_pkg::S_P12: begin
					rb_q <= 64'sd1048576 - $signed({44'd0, in_q.raw_press[23:4]});
					if (ra_q == 64'sd0)
						res_q.press_status <= esc_pkg::PST_DIVZ;
				end
				esc_pkg::S_P13: rb_q <= (rb_q <<< 31) - rc_q;
				esc_pkg::S_P16: rc_q <= rb_q >>> 13;
				esc_pkg::S_P19: rd_q <= rd_q >>> 25;
				esc_pkg::S_P21: ra_q <= ra_q >>> 19;
				esc_pkg::S_P22: rb_q <= rb_q + rd_q;
				esc_pkg::S_P23: rb_q <= rb_q + ra_q;
				esc_pkg::S_P24: begin
					if (ps < 64'sd0)
						res_q.press_q24_8 <= 32'd0;
					else if (ps > 64'sd4294967295)
						res_q.press_q24_8 <= 32'hFFFFFFFF;
					else
						res_q.press_q24_8 <= ps[31:0];
					res_q.press_status <= esc_pkg::PST_OK;
				end
				esc_pkg::S_H0: begin
					ra_q <= esc_pkg::w32(fine_s - 64'sd76800);
					rb_q <= esc_pkg::w32($signed({34'd0, in_q.raw_hum, 14'd0}) - (h4 <<< 20));
				end
				esc_pkg::S_H2:  rb_q <= esc_pkg::w32(rb_q - esc_pkg::w32(rc_q));
				esc_pkg::S_H3:  rb_q <= esc_pkg::w32(rb_q + 64'sd16384) >>> 15;
				esc_pkg::S_H5:  rc_q <= esc_pkg::w32((esc_pkg::w32(rc_q) >>> 11) + 64'sd32768);
				esc_pkg::S_H7:  rd_q <= esc_pkg::w32(rd_q) >>> 10;
				esc_pkg::S_H9:  rd_q <= esc_pkg::w32((esc_pkg::w32(rd_q) >>> 10) + 64'sd2097152);
				esc_pkg::S_H11: rd_q <= esc_pkg::w32(rd_q + 64'sd8192) >>> 14;
				esc_pkg::S_H13: begin
					ra_q <= esc_pkg::w32(ra_q);
					rc_q <= esc_pkg::w32(ra_q) >>> 15;
				end
				esc_pkg::S_H15: rc_q <= esc_pkg::w32(rc_q) >>> 7;
				esc_pkg::S_H17: rc_q <= esc_pkg::w32(rc_q) >>> 4;
				esc_pkg::S_H18: begin
					if (hv < 64'sd0)
						res_q.hum_q22_10 <= 17'd0;
					else if (hv > 64'sd419430400)
						res_q.hum_q22_10 <= 17'd102400;
					else
						res_q.hum_q22_10 <= hv[28:12];
					res_q.hum_ok <= 1'b1;
				end
				default: ;
			endcase
		end
		if (cmd.load_out) begin
			out_q <= res_q;
		end
	end

	// output register handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	assign st.mul_done = mul_done;
	assign st.div_done = div_done;
	assign st.mul_busy = mul_busy;
	assign st.div_busy = div_busy;
	assign st.t_en     = (in_q.raw_temp != esc_pkg::RAW_OFF24);
	assign st.p_en     = (in_q.raw_press != esc_pkg::RAW_OFF24);
	assign st.h_en     = (in_q.raw_hum != esc_pkg::RAW_OFF16);
	assign st.a_zero   = (ra_q == 64'sd0);
	assign st.out_free = !out_valid_q || !result_stall;

	// fine temperature only moves on its own step
	a_fine_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(go_alu && cmd.step == esc_pkg::S_T5) |=> $stable(fine_q))
		else $error("fine temperature changed outside its step");

	// the two shared units never finish together
	a_one_done: assert property (@(posedge clk) disable iff (!arst_n)
		!(mul_done && div_done))
		else $error("multiplier and divider finished together");

endmodule

// ===== src/esc_ctrl.sv =====
// ---------------------------------------------------------------------------
// esc_ctrl: step sequencer
// Walks the compensation steps, waits on the shared units, skips disabled
// measurements and hands the finished item to the output register.
// ---------------------------------------------------------------------------
module esc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sample_valid,
	output logic               sample_stall,
	input  esc_pkg::esc_stat_t st,
	output esc_pkg::esc_cmd_t  cmd
);

	logic [5:0] state_q, state_d, next_step;
	logic [5:0] after_temp, after_press;
	logic       wait_q, wait_d;
	logic [1:0] kind;
	logic       unit_done;

	assign after_press = st.h_en ? esc_pkg::S_H0 : esc_pkg::S_FIN;
	assign after_temp  = st.p_en ? esc_pkg::S_P0 : after_press;
	assign kind        = esc_pkg::step_kind(state_q);
	assign unit_done   = (kind == esc_pkg::KIND_MUL) ? st.mul_done : st.div_done;

	// branch points of the step sequence
	always_comb begin
		unique case (state_q)
			esc_pkg::S_START: next_step = st.t_en ? esc_pkg::S_T0 : after_temp;
			esc_pkg::S_T6:    next_step = after_temp;
			esc_pkg::S_P12:   next_step = st.a_zero ? after_press : esc_pkg::S_P13;
			esc_pkg::S_P24:   next_step = after_press;
			default:          next_step = state_q + 6'd1;
		endcase
	end

	// advance, issue and wait
	always_comb begin
		state_d      = state_q;
		wait_d       = wait_q;
		cmd.step     = state_q;
		cmd.go       = 1'b0;
		cmd.load_in  = 1'b0;
		cmd.load_out = 1'b0;
		priority if (state_q == esc_pkg::S_IDLE) begin
			cmd.load_in = sample_valid;
			if (sample_valid)
				state_d = esc_pkg::S_START;
		end else if (state_q == esc_pkg::S_FIN) begin
			cmd.load_out = st.out_free;
			if (st.out_free)
				state_d = esc_pkg::S_IDLE;
		end else if (kind == esc_pkg::KIND_ALU) begin
			cmd.go  = 1'b1;
			state_d = next_step;
		end else if (!wait_q) begin
			cmd.go = 1'b1;
			wait_d = 1'b1;
		end else if (unit_done) begin
			wait_d  = 1'b0;
			state_d = next_step;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= esc_pkg::S_IDLE;
			wait_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			wait_q  <= wait_d;
		end
	end

	assign sample_stall = (state_q != esc_pkg::S_IDLE);

	// no unit is left running once the sequence is back at rest
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == esc_pkg::S_IDLE) |-> (!wait_q && !st.mul_busy && !st.div_busy))
		else $error("unit busy while sequencer idle");

	// a result is only loaded into a free output register
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> st.out_free)
		else $error("result loaded over a pending one");

	// waiting only happens on multiplier or divider steps
	a_wait_kind: assert property (@(posedge clk) disable iff (!arst_n)
		wait_q |-> (kind == esc_pkg::KIND_MUL || kind == esc_pkg::KIND_DIV))
		else $error("wait on an ALU step");

endmodule

// ===== src/env_sensor_compensation_unit.sv =====
// ---------------------------------------------------------------------------
// env_sensor_compensation_unit: integer compensation of raw T/P/H readings
// Sequencer plus datapath with one shared multiplier and a serial divider.
//
//   channel  | signals                               | flow
//   ---------+---------------------------------------+-----------
//   sample   | sample_valid, sample_stall, sample    | in
//   result   | result_valid, result_stall, result    | out
//   config   | cfg_valid, cfg_ready, cfg_index/data  | in
//
// An item takes longest with all readings enabled and least time with all
// disabled; the shared multiplier works at one 16-bit digit a cycle, and
// the pressure division runs on the serial divider.
// Reset clears the trims and the fine temperature to zero.
// A new sample is taken while the previous result waits in the output
// register; a stalled result only holds the sequencer at its last step.
// ---------------------------------------------------------------------------
module env_sensor_compensation_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sample_valid,
	output logic               sample_stall,
	input  esc_pkg::in_item_t  sample,
	output logic               result_valid,
	input  logic               result_stall,
	output esc_pkg::out_item_t result,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [63:0]        cfg_data
);

	esc_pkg::esc_cmd_t  cmd;
	esc_pkg::esc_stat_t st;

	assign cfg_ready = 1'b1;

	esc_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.st           (st),
		.cmd          (cmd)
	);

	esc_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.st           (st),
		.sample       (sample),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule
